// File: src/aesc_pkg.sv
// Shared constants and types for the agent Euler step block.
`default_nettype none
package aesc_pkg;
  localparam int FRAC_BITS = 16;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

  localparam int HEAD_W = 18;
  localparam logic signed [HEAD_W-1:0] HEAD_MAX = 18'sd131071;
  localparam logic signed [HEAD_W-1:0] HEAD_MIN = -18'sd131072;

  // register indexes on the config port
  localparam logic [1:0] REG_MASS  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_EPS   = 2'd2;

  // shared iterative unit operations
  localparam logic OP_DIV  = 1'b0;
  localparam logic OP_SQRT = 1'b1;

  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic start;
    logic op;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_rsp_t;
endpackage
`default_nettype wire

// File: src/aesc_if.sv
// Valid/ready channel interfaces for step requests and results.
`default_nettype none
interface aesc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic [30:0] time_step;
  logic signed [31:0] load_pos_x;
  logic signed [31:0] load_pos_y;
  logic signed [31:0] load_vel_x;
  logic signed [31:0] load_vel_y;
  logic signed [17:0] load_head_x;
  logic signed [17:0] load_head_y;
  modport source (output valid, action, force_x, force_y, time_step, load_pos_x,
                  load_pos_y, load_vel_x, load_vel_y, load_head_x, load_head_y,
                  input ready);
  modport sink (input valid, action, force_x, force_y, time_step, load_pos_x,
                load_pos_y, load_vel_x, load_vel_y, load_head_x, load_head_y,
                output ready);
endinterface

interface aesc_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [17:0] head_x;
  logic signed [17:0] head_y;
  logic signed [17:0] side_x;
  logic signed [17:0] side_y;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, head_x, head_y, side_x,
                  side_y, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, head_x, head_y, side_x,
                side_y, output ready);
endinterface
`default_nettype wire

// File: src/aesc_iter_unit.sv
// Shared bit-serial unit: restoring divide (1 bit/cycle) and integer square root.
`default_nettype none
module aesc_iter_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire aesc_pkg::iter_req_t req,
  input  wire logic [63:0]         num,
  input  wire logic [31:0]         den,
  output aesc_pkg::iter_rsp_t      rsp,
  output logic [63:0]              res
);
  import aesc_pkg::*;

  logic [63:0]      n;
  logic [31:0]      d;
  logic [35:0]      rem;
  logic [63:0]      q;
  logic [CNT_W-1:0] cnt;
  logic             op;
  logic             busy;
  logic             done;

  logic [35:0] sh;
  logic [35:0] trial;
  logic        ge;
  logic [35:0] diff;

  always_comb begin
    if (op == OP_SQRT) begin
      sh    = {rem[33:0], n[63:62]};
      trial = {2'b00, q[31:0], 2'b01};
    end else begin
      sh    = {rem[34:0], n[63]};
      trial = {4'd0, d};
    end
    ge   = sh >= trial;
    diff = sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        n    <= num;
        d    <= den;
        rem  <= '0;
        q    <= '0;
        cnt  <= (req.op == OP_SQRT) ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        rem <= ge ? diff : sh;
        q   <= {q[62:0], ge};
        n   <= (op == OP_SQRT) ? {n[61:0], 2'b00} : {n[62:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign res      = q;
endmodule
`default_nettype wire

// File: src/agent_euler_step_speed_clamp_core.sv
// Top level: agent state, step sequencer, shared multiplier and iterative unit.
// A load goes straight to the done state; a step runs two to six divides and up to two
// square roots on the iterative unit, plus multiply and accumulate sequencing states.
// Throughput: one request at a time; the next is taken the cycle after the result is posted.
// Reset (synchronous): state zero, heading (1.0, 0), mass 1.0, limit 1.0, epsilon 1.
`default_nettype none
module agent_euler_step_speed_clamp_core (
  input  wire logic  clk,
  input  wire logic  rst,
  aesc_in_if.sink    step_in,
  aesc_out_if.source result_out,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [30:0] cfg_data
);
  import aesc_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DONE   = 5'd1;
  localparam logic [4:0] S_DIV_AX = 5'd2;
  localparam logic [4:0] S_DIV_AY = 5'd3;
  localparam logic [4:0] S_MUL_VX = 5'd4;
  localparam logic [4:0] S_ACC_VX = 5'd5;
  localparam logic [4:0] S_MUL_VY = 5'd6;
  localparam logic [4:0] S_ACC_VY = 5'd7;
  localparam logic [4:0] S_SQ_X   = 5'd8;
  localparam logic [4:0] S_SQ_Y   = 5'd9;
  localparam logic [4:0] S_SQ_L   = 5'd10;
  localparam logic [4:0] S_CMP    = 5'd11;
  localparam logic [4:0] S_SQRT   = 5'd12;
  localparam logic [4:0] S_MUL_CX = 5'd13;
  localparam logic [4:0] S_DIV_CX = 5'd14;
  localparam logic [4:0] S_MUL_CY = 5'd15;
  localparam logic [4:0] S_DIV_CY = 5'd16;
  localparam logic [4:0] S_MUL_PX = 5'd17;
  localparam logic [4:0] S_ACC_PX = 5'd18;
  localparam logic [4:0] S_MUL_PY = 5'd19;
  localparam logic [4:0] S_ACC_PY = 5'd20;
  localparam logic [4:0] S_DIV_HX = 5'd21;
  localparam logic [4:0] S_DIV_HY = 5'd22;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic [63:0] Q32_MAX = 64'd2147483647;
  localparam logic [63:0] Q18_MAX = 64'd131071;
  localparam logic signed [HEAD_W-1:0] HEAD_ONE =
    (ONE_Q > Q18_MAX) ? HEAD_MAX : HEAD_W'(ONE_Q);

  function automatic logic signed [63:0] trunc_frac(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + $signed(p[63] ? ONE_Q - 64'd1 : 64'd0);
    return adj >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX) return 32'sh7fffffff;
    if (v < S32_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sext32(input logic signed [31:0] v);
    return $signed({{32{v[31]}}, v});
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // signed result from quotient magnitude, clamped to 32 bits
  function automatic logic signed [31:0] apply_sign32(input logic neg, input logic [63:0] q);
    if (!neg) return (q > Q32_MAX) ? 32'sh7fffffff : $signed(q[31:0]);
    if (q > Q32_MAX + 64'd1) return 32'sh80000000;
    return $signed(32'(-q[31:0]));
  endfunction

  function automatic logic signed [HEAD_W-1:0] apply_sign18(input logic neg,
                                                             input logic [63:0] q);
    if (!neg) return (q > Q18_MAX) ? HEAD_MAX : $signed(q[HEAD_W-1:0]);
    if (q > Q18_MAX + 64'd1) return HEAD_MIN;
    return $signed(HEAD_W'(-q[HEAD_W-1:0]));
  endfunction

  logic [30:0] agent_mass, speed_limit, still_epsilon;

  logic signed [31:0] position_x, position_y, velocity_x, velocity_y;
  logic signed [HEAD_W-1:0] heading_x, heading_y;

  logic signed [31:0] force_x, force_y, accel_x, accel_y;
  logic [30:0] time_step;
  logic [31:0] len;
  logic [63:0] l2;
  logic        phase;
  logic        issued;
  logic        dsign;
  logic [4:0]  state;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  iter_req_t   ireq;
  iter_rsp_t   irsp;
  logic [63:0] inum;
  logic [31:0] iden;
  logic [63:0] ires;
  logic        isign;
  logic        arith;
  logic        out_free;

  logic signed [31:0] acc_sum;

  aesc_iter_unit u_iter (
    .clk (clk),
    .rst (rst),
    .req (ireq),
    .num (inum),
    .den (iden),
    .rsp (irsp),
    .res (ires)
  );

  assign arith = (state == S_DIV_AX) || (state == S_DIV_AY) || (state == S_SQRT) ||
                 (state == S_DIV_CX) || (state == S_DIV_CY) || (state == S_DIV_HX) ||
                 (state == S_DIV_HY);
  assign ireq.start = arith && !issued;
  assign ireq.op    = (state == S_SQRT) ? OP_SQRT : OP_DIV;
  assign out_free   = !result_out.valid || result_out.ready;
  assign step_in.ready = (state == S_IDLE);

  // operand selection for the shared unit
  always_comb begin
    inum  = '0;
    iden  = 32'd1;
    isign = 1'b0;
    case (state)
      S_DIV_AX: begin
        inum  = abs64(sext32(force_x)) << FRAC_BITS;
        iden  = (agent_mass == '0) ? 32'd1 : {1'b0, agent_mass};
        isign = force_x[31];
      end
      S_DIV_AY: begin
        inum  = abs64(sext32(force_y)) << FRAC_BITS;
        iden  = (agent_mass == '0) ? 32'd1 : {1'b0, agent_mass};
        isign = force_y[31];
      end
      S_SQRT: inum = l2;
      S_DIV_CX, S_DIV_CY: begin
        inum  = abs64(prod);
        iden  = len;
        isign = prod[63];
      end
      S_DIV_HX: begin
        inum  = abs64(sext32(velocity_x)) << FRAC_BITS;
        iden  = len;
        isign = velocity_x[31];
      end
      S_DIV_HY: begin
        inum  = abs64(sext32(velocity_y)) << FRAC_BITS;
        iden  = len;
        isign = velocity_y[31];
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_VX: begin mul_a = accel_x;    mul_b = $signed({1'b0, time_step}); end
      S_MUL_VY: begin mul_a = accel_y;    mul_b = $signed({1'b0, time_step}); end
      S_SQ_X:   begin mul_a = velocity_x; mul_b = velocity_x; end
      S_SQ_Y:   begin mul_a = velocity_y; mul_b = velocity_y; end
      S_SQ_L: begin
        mul_a = $signed({1'b0, speed_limit});
        mul_b = $signed({1'b0, speed_limit});
      end
      S_MUL_CX: begin mul_a = velocity_x; mul_b = $signed({1'b0, speed_limit}); end
      S_MUL_CY: begin mul_a = velocity_y; mul_b = $signed({1'b0, speed_limit}); end
      S_MUL_PX: begin mul_a = velocity_x; mul_b = $signed({1'b0, time_step}); end
      S_MUL_PY: begin mul_a = velocity_y; mul_b = $signed({1'b0, time_step}); end
      default: ;
    endcase
  end

  always_comb begin
    acc_sum = '0;
    case (state)
      S_ACC_VX: acc_sum = sat32(sext32(velocity_x) + trunc_frac(prod));
      S_ACC_VY: acc_sum = sat32(sext32(velocity_y) + trunc_frac(prod));
      S_ACC_PX: acc_sum = sat32(sext32(position_x) + trunc_frac(prod));
      S_ACC_PY: acc_sum = sat32(sext32(position_y) + trunc_frac(prod));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      agent_mass    <= 31'(ONE_Q);
      speed_limit   <= 31'(ONE_Q);
      still_epsilon <= 31'd1;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MASS:  agent_mass    <= cfg_data;
        REG_LIMIT: speed_limit   <= cfg_data;
        REG_EPS:   still_epsilon <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issued     <= 1'b0;
      phase      <= 1'b0;
      position_x <= '0;
      position_y <= '0;
      velocity_x <= '0;
      velocity_y <= '0;
      heading_x  <= HEAD_ONE;
      heading_y  <= '0;
      result_out.valid <= 1'b0;
    end else begin
      // the done state posts the next result itself
      if (result_out.valid && result_out.ready && state != S_DONE)
        result_out.valid <= 1'b0;
      if (ireq.start) begin
        issued <= 1'b1;
        dsign  <= isign;
      end
      if (irsp.done) issued <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (step_in.valid) begin
            force_x   <= step_in.force_x;
            force_y   <= step_in.force_y;
            time_step <= step_in.time_step;
            phase     <= 1'b0;
            if (step_in.action) begin
              position_x <= step_in.load_pos_x;
              position_y <= step_in.load_pos_y;
              velocity_x <= step_in.load_vel_x;
              velocity_y <= step_in.load_vel_y;
              heading_x  <= step_in.load_head_x;
              heading_y  <= step_in.load_head_y;
              state      <= S_DONE;
            end else begin
              state <= S_DIV_AX;
            end
          end
        end
        S_DIV_AX: if (irsp.done) begin
          accel_x <= apply_sign32(dsign, ires);
          state   <= S_DIV_AY;
        end
        S_DIV_AY: if (irsp.done) begin
          accel_y <= apply_sign32(dsign, ires);
          state   <= S_MUL_VX;
        end
        S_MUL_VX: state <= S_ACC_VX;
        S_ACC_VX: begin velocity_x <= acc_sum; state <= S_MUL_VY; end
        S_MUL_VY: state <= S_ACC_VY;
        S_ACC_VY: begin velocity_y <= acc_sum; state <= S_SQ_X; end
        S_SQ_X: state <= S_SQ_Y;
        S_SQ_Y: begin l2 <= prod; state <= S_SQ_L; end
        S_SQ_L: begin l2 <= l2 + prod; state <= S_CMP; end
        S_CMP: begin
          // prod now holds the squared speed limit
          if (!phase) state <= (l2 > prod) ? S_SQRT : S_MUL_PX;
          else state <= ((l2 >> FRAC_BITS) > {33'd0, still_epsilon}) ? S_SQRT : S_DONE;
        end
        S_SQRT: if (irsp.done) begin
          len   <= ires[31:0];
          state <= phase ? S_DIV_HX : S_MUL_CX;
        end
        S_MUL_CX: state <= S_DIV_CX;
        S_DIV_CX: if (irsp.done) begin
          velocity_x <= apply_sign32(dsign, ires);
          state      <= S_MUL_CY;
        end
        S_MUL_CY: state <= S_DIV_CY;
        S_DIV_CY: if (irsp.done) begin
          velocity_y <= apply_sign32(dsign, ires);
          state      <= S_MUL_PX;
        end
        S_MUL_PX: state <= S_ACC_PX;
        S_ACC_PX: begin position_x <= acc_sum; state <= S_MUL_PY; end
        S_MUL_PY: state <= S_ACC_PY;
        S_ACC_PY: begin
          position_y <= acc_sum;
          phase      <= 1'b1;
          state      <= S_SQ_X;
        end
        S_DIV_HX: if (irsp.done) begin
          heading_x <= apply_sign18(dsign, ires);
          state     <= S_DIV_HY;
        end
        S_DIV_HY: if (irsp.done) begin
          heading_y <= apply_sign18(dsign, ires);
          state     <= S_DONE;
        end
        S_DONE: if (out_free) begin
          result_out.valid  <= 1'b1;
          result_out.pos_x  <= position_x;
          result_out.pos_y  <= position_y;
          result_out.vel_x  <= velocity_x;
          result_out.vel_y  <= velocity_y;
          result_out.head_x <= heading_x;
          result_out.head_y <= heading_y;
          result_out.side_x <= (heading_y == HEAD_MIN) ? HEAD_MAX : -heading_y;
          result_out.side_y <= heading_x;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_arith: assert property (@(posedge clk) disable iff (rst)
    irsp.done |-> arith && issued)
    else $error("iterative unit finished outside an arithmetic state");

  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    ireq.start |-> !irsp.busy)
    else $error("iterative unit started while busy");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (step_in.valid && step_in.ready) |=> (state != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_done_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> result_out.valid && state == S_IDLE)
    else $error("result not posted from done state");
endmodule
`default_nettype wire
